// ===== hdl/lzw_pkg.sv =====
// Package for the LZW stream decoder: widths, sizes, state and command types.
// Depends on nothing; every module of the decoder imports it.
`default_nettype none
package lzw_pkg;
  localparam int CodeWidth  = 10;
  localparam int MaxString  = 31;
  localparam int SlotBytes  = MaxString + 1;
  localparam int LenW       = $clog2(SlotBytes);
  localparam int TableCodes = 1 << CodeWidth;
  localparam int NfcW       = CodeWidth + 1;
  localparam int DictAw     = CodeWidth + LenW;
  localparam int HoldW      = 16;
  localparam int CntW       = 5;
  localparam int QDepth     = 4;
  localparam int QAw        = 2;
  localparam logic [NfcW-1:0] FirstFree = NfcW'(256);

  typedef struct packed {
    logic                 restart;
    logic [CodeWidth-1:0] code;
  } lzw_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_COPY, ST_TAIL, ST_EMIT
  } lzw_state_t;
endpackage
`default_nettype wire

// ===== hdl/lzw_front.sv =====
// Front end: takes packed bytes, unpacks 10-bit codes MSB first, queues them.
// Depends on lzw_pkg.
`default_nettype none
module lzw_front import lzw_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_stream_start,
  output logic            cmd_valid,
  output lzw_cmd_t        cmd,
  input  wire logic       cmd_take
);
  logic [HoldW-1:0] hold_r, hold_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             rst_pend_r, rst_pend_nxt;
  lzw_cmd_t         q_r [QDepth];
  logic [QAw:0]     fill_r;
  logic [QAw-1:0]   wp_r, rp_r;
  logic             acc, emit_code;
  logic [23:0]      wide;
  logic [CntW-1:0]  cnt_tot;
  logic [CodeWidth-1:0] code_w;

  assign in_full = (fill_r == (QAw+1)'(QDepth));
  assign acc     = in_push && !in_full;

  always_comb begin
    logic [HoldW-1:0] h0;
    logic [CntW-1:0]  c0;
    h0 = in_stream_start ? '0 : hold_r;
    c0 = in_stream_start ? '0 : cnt_r;
    wide     = {h0, in_data_byte};
    cnt_tot  = c0 + CntW'(8);
    emit_code = cnt_tot >= CntW'(CodeWidth);
    code_w   = CodeWidth'(wide >> (cnt_tot - CntW'(CodeWidth)));
    hold_nxt = hold_r;
    cnt_nxt  = cnt_r;
    rst_pend_nxt = rst_pend_r;
    if (acc) begin
      if (emit_code) begin
        cnt_nxt  = cnt_tot - CntW'(CodeWidth);
        hold_nxt = HoldW'(wide) & ((HoldW'(1) << cnt_nxt) - HoldW'(1));
        rst_pend_nxt = 1'b0;
      end else begin
        cnt_nxt  = cnt_tot;
        hold_nxt = HoldW'(wide);
        rst_pend_nxt = rst_pend_r | in_stream_start;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= '0; cnt_r <= '0; rst_pend_r <= 1'b0;
      fill_r <= '0; wp_r <= '0; rp_r <= '0;
    end else begin
      hold_r <= hold_nxt; cnt_r <= cnt_nxt; rst_pend_r <= rst_pend_nxt;
      if (acc && emit_code) wp_r <= wp_r + QAw'(1);
      if (cmd_take) rp_r <= rp_r + QAw'(1);
      fill_r <= fill_r + (QAw+1)'(acc && emit_code) - (QAw+1)'(cmd_take);
    end
  end

  always_ff @(posedge clk) begin
    if (acc && emit_code) begin
      q_r[wp_r].restart <= rst_pend_r | in_stream_start;
      q_r[wp_r].code    <= code_w;
    end
  end

  assign cmd_valid = fill_r != '0;
  assign cmd       = q_r[rp_r];
endmodule
`default_nettype wire

// ===== hdl/lzw_back.sv =====
// Back end: decodes one queued code through the dictionary, one byte a cycle unless held.
// Depends on lzw_pkg; holds the dictionary and previous-string memories.
`default_nettype none
module lzw_back import lzw_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cmd_valid,
  input  lzw_cmd_t        cmd,
  output logic            cmd_take,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [7:0]      out_out_byte,
  output logic            out_last_of_run
);
  logic [7:0]      dict_mem [TableCodes*SlotBytes];
  logic [LenW-1:0] len_mem  [TableCodes];
  logic [7:0]      prev_mem [SlotBytes];
  logic [7:0]      cur_mem  [SlotBytes];

  lzw_state_t st_r, st_nxt;
  logic [CodeWidth-1:0] code_r, code_nxt;
  logic [NfcW-1:0] nfc_r, nfc_nxt;
  logic            havep_r, havep_nxt;
  logic [LenW-1:0] plen_r, plen_nxt;
  logic [LenW-1:0] clen_r, clen_nxt;
  logic [LenW-1:0] idx_r, idx_nxt;
  logic [1:0]      src_r, src_nxt;  // 0 literal, 1 dict, 2 previous
  logic [7:0]      first_r, first_nxt;
  logic [7:0]      dict_q, len_lo, prev_q;
  logic [LenW-1:0] len_q;
  logic            rd_pend_r;
  logic [7:0]      ob_r;
  logic            ol_r, ov_r;
  logic            obuf_free;
  logic            cur_we;
  logic [LenW-1:0] cur_wa;
  logic [7:0]      cur_wd, cur_q;
  logic            dict_we;
  logic [DictAw-1:0] dict_wa;
  logic [7:0]      dict_wd;
  logic            len_we;
  logic [LenW-1:0] len_wd;
  logic [LenW-1:0] rd_idx;
  logic [7:0]      src_byte;

  localparam logic [1:0] SrcLit = 2'd0, SrcDict = 2'd1, SrcPrev = 2'd2;

  assign obuf_free = !ov_r || out_pop;
  assign rd_idx = idx_nxt;
  assign len_lo = '0;

  always_ff @(posedge clk) begin
    dict_q <= dict_mem[{code_nxt, rd_idx}];
    len_q  <= len_mem[code_nxt];
    prev_q <= prev_mem[rd_idx];
    cur_q  <= cur_mem[rd_idx];
    if (dict_we) dict_mem[dict_wa] <= dict_wd;
    if (len_we)  len_mem[nfc_r[CodeWidth-1:0]] <= len_wd;
    if (cur_we)  cur_mem[cur_wa] <= cur_wd;
    if (st_r == ST_EMIT && obuf_free) prev_mem[idx_r] <= cur_q;
  end

  assign src_byte = (src_r == SrcDict) ? dict_q : prev_q;

  // Next state and control registers.
  always_comb begin
    st_nxt = st_r; code_nxt = code_r; nfc_nxt = nfc_r; havep_nxt = havep_r;
    plen_nxt = plen_r; clen_nxt = clen_r; idx_nxt = idx_r; src_nxt = src_r;
    first_nxt = first_r;
    unique case (st_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (cmd_valid) begin
          code_nxt = cmd.code;
          if (cmd.restart) begin
            nfc_nxt = FirstFree; havep_nxt = 1'b0; plen_nxt = '0;
          end
          st_nxt = ST_READ;
        end
      end
      ST_READ: begin
        // byte 0 of each source is valid now; pick the source and length
        idx_nxt = '0;
        if (NfcW'(code_r) < FirstFree) begin
          src_nxt = SrcLit; clen_nxt = LenW'(1);
          first_nxt = code_r[7:0];
          st_nxt = ST_TAIL;
        end else if (NfcW'(code_r) < nfc_r) begin
          src_nxt = SrcDict; clen_nxt = len_q; first_nxt = dict_q;
          st_nxt = ST_COPY;
        end else begin
          src_nxt = SrcPrev; first_nxt = prev_q;
          clen_nxt = (plen_r != '0 && plen_r != LenW'(MaxString))
                     ? plen_r + LenW'(1) : plen_r;
          st_nxt = ST_COPY;
        end
      end
      ST_COPY: begin
        // byte idx_r of source and previous string is valid now
        idx_nxt = idx_r + LenW'(1);
        if (idx_r == LenW'(MaxString-1)) begin
          st_nxt = ST_TAIL; idx_nxt = '0;
        end
      end
      ST_TAIL: begin
        if (src_r != SrcLit || idx_r == LenW'(SlotBytes-1)) begin
          if (havep_r) begin
            if (nfc_r < NfcW'(TableCodes)) nfc_nxt = nfc_r + NfcW'(1);
            else nfc_nxt = FirstFree;
          end
          havep_nxt = 1'b1;
          plen_nxt = clen_r;
          idx_nxt = '0;
          st_nxt = (clen_r == '0) ? ST_IDLE : ST_EMIT;
        end else idx_nxt = idx_r + LenW'(1);
      end
      ST_EMIT: begin
        if (obuf_free) begin
          idx_nxt = idx_r + LenW'(1);
          if (idx_r + LenW'(1) == clen_r) begin
            st_nxt = ST_IDLE; idx_nxt = '0;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Queue take and memory writes.
  always_comb begin
    cmd_take = 1'b0;
    cur_we = 1'b0; cur_wa = idx_r; cur_wd = src_byte;
    dict_we = 1'b0; dict_wa = {nfc_r[CodeWidth-1:0], idx_r}; dict_wd = prev_q;
    len_we = 1'b0; len_wd = plen_r;
    unique case (st_r)
      ST_IDLE: cmd_take = cmd_valid;
      ST_READ: begin
        if (NfcW'(code_r) < FirstFree) begin
          cur_we = 1'b1; cur_wa = '0; cur_wd = code_r[7:0];
        end
      end
      ST_COPY: begin
        // copy one byte of source and previous string per cycle
        cur_we = idx_r < ((src_r == SrcPrev) ? plen_r : clen_r);
        dict_we = havep_r && nfc_r < NfcW'(TableCodes) && idx_r < plen_r;
      end
      ST_TAIL: begin
        if (src_r == SrcLit && havep_r && nfc_r < NfcW'(TableCodes)) begin
          // literal: copy previous into the new slot one byte a cycle
          dict_we = idx_r < plen_r;
        end
        if (src_r == SrcPrev && clen_r != plen_r) begin
          cur_we = 1'b1; cur_wa = plen_r; cur_wd = first_r;
        end
        if ((src_r != SrcLit || idx_r == LenW'(SlotBytes-1)) && havep_r
            && nfc_r < NfcW'(TableCodes)) begin
          len_we = 1'b1;
          if (clen_r != '0 && plen_r != LenW'(MaxString)) begin
            dict_we = 1'b1; dict_wa = {nfc_r[CodeWidth-1:0], plen_r};
            dict_wd = first_r;
            len_wd = plen_r + LenW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; nfc_r <= FirstFree; havep_r <= 1'b0; plen_r <= '0;
      idx_r <= '0; ov_r <= 1'b0; rd_pend_r <= 1'b0;
    end else begin
      st_r <= st_nxt; nfc_r <= nfc_nxt; havep_r <= havep_nxt; plen_r <= plen_nxt;
      idx_r <= idx_nxt; rd_pend_r <= (st_nxt == ST_EMIT);
      if (st_r == ST_EMIT && obuf_free) ov_r <= 1'b1;
      else if (out_pop) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt; clen_r <= clen_nxt; src_r <= src_nxt; first_r <= first_nxt;
    if (st_r == ST_EMIT && obuf_free) begin
      ob_r <= cur_q | len_lo;
      ol_r <= (idx_r + LenW'(1) == clen_r) && rd_pend_r;
    end
  end

  assign out_empty       = !ov_r;
  assign out_out_byte    = ob_r;
  assign out_last_of_run = ol_r;
endmodule
`default_nettype wire

// ===== hdl/lzw_stream_decoder.sv =====
// Top level of the LZW stream decoder: byte front end, queue, dictionary back end.
// Depends on lzw_pkg, lzw_front and lzw_back.
//
//   channel | ports                                   | handshake
//   input   | in_data_byte, in_stream_start           | in_push / in_full
//   result  | out_out_byte, out_last_of_run           | out_pop / out_empty
//
// A byte is taken whenever in_full is low; a completed code queues for the back end.
// The back end walks the 32-byte dictionary slot of a code one byte a cycle, then
// emits its decoded bytes one a cycle while the result register is free.
// Reset (rst_n low, synchronous) clears control; the memories hold until written.
// A full code queue raises in_full; an untaken result holds the back end.
`default_nettype none
module lzw_stream_decoder import lzw_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_stream_start,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [7:0]      out_out_byte,
  output logic            out_last_of_run
);
  logic     cmd_valid, cmd_take;
  lzw_cmd_t cmd;

  lzw_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data_byte, .in_stream_start,
    .cmd_valid, .cmd, .cmd_take
  );

  lzw_back u_back (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_take,
    .out_empty, .out_pop, .out_out_byte, .out_last_of_run
  );
endmodule
`default_nettype wire

// ===== hdl/lzw_checker.sv =====
// Port-level checker for the LZW stream decoder, bound to the top level.
// Depends on nothing but the top-level ports.
`default_nettype none
module lzw_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_full,
  input wire logic       out_empty,
  input wire logic       out_pop,
  input wire logic [7:0] out_out_byte,
  input wire logic       out_last_of_run
);
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result not empty after reset");
  a_rst_full: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full after reset");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_out_byte)
    && $stable(out_last_of_run)))
    else $error("waiting result changed");
endmodule
bind lzw_stream_decoder lzw_checker u_chk (.*);
`default_nettype wire
